// ===== hw/rtl/bin_set_routing_lookup_defines.svh =====
// Assertion macros for the bin-set routing lookup.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BIN_SET_ROUTING_LOOKUP_DEFINES_SVH
`define BIN_SET_ROUTING_LOOKUP_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define BSRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while in reset.
`define BSRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bsrl_pkg.sv =====
// Types, codes and microprogram for the bin-set routing lookup.
// No dependencies; used by bsrl_seq and bin_set_routing_lookup.
`default_nettype none

package bsrl_pkg;

  localparam int unsigned HEADER_WORDS = 3;
  localparam logic [10:0] OFFSET_MAX   = 11'd2047;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_INTER_BINS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 1'd1;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_B_LOOP  = 4'd1,
    S_B_ADV   = 4'd2,
    S_B_END   = 4'd3,
    S_Q_BIN   = 4'd4,
    S_Q_LO    = 4'd5,
    S_Q_HI    = 4'd6,
    S_Q_PROBE = 4'd7,
    S_Q_CMP   = 4'd8,
    S_Q_NEXT  = 4'd9,
    S_Q_HIT   = 4'd10,
    S_Q_MISS  = 4'd11
  } step_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_B_INDEX,
    OP_B_ADV,
    OP_B_END,
    OP_Q_RD_LO,
    OP_Q_RD_HI,
    OP_Q_SET_HI,
    OP_Q_PROBE,
    OP_Q_CMP,
    OP_Q_NEXT,
    OP_Q_HIT,
    OP_Q_MISS
  } op_t;

  typedef enum logic [2:0] {
    C_TRUE,
    C_DISPATCH,
    C_BIN_DONE,
    C_SCAN_DONE,
    C_RANGE_EMPTY,
    C_MATCH,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic       in_fire;
    logic [1:0] mode;
    logic       bin_done;
    logic       scan_done;
    logic       range_empty;
    logic       match;
    logic       out_free;
  } status_t;

  typedef struct packed {
    step_t step;
    op_t   op;
  } ctrl_t;

  // Microprogram ROM
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      S_IDLE:    w = '{OP_IDLE,     C_DISPATCH,    S_IDLE,    S_IDLE};
      S_B_LOOP:  w = '{OP_B_INDEX,  C_BIN_DONE,    S_B_END,   S_B_ADV};
      S_B_ADV:   w = '{OP_B_ADV,    C_TRUE,        S_B_LOOP,  S_B_LOOP};
      S_B_END:   w = '{OP_B_END,    C_TRUE,        S_IDLE,    S_IDLE};
      S_Q_BIN:   w = '{OP_Q_RD_LO,  C_SCAN_DONE,   S_Q_MISS,  S_Q_LO};
      S_Q_LO:    w = '{OP_Q_RD_HI,  C_TRUE,        S_Q_HI,    S_Q_HI};
      S_Q_HI:    w = '{OP_Q_SET_HI, C_TRUE,        S_Q_PROBE, S_Q_PROBE};
      S_Q_PROBE: w = '{OP_Q_PROBE,  C_RANGE_EMPTY, S_Q_NEXT,  S_Q_CMP};
      S_Q_CMP:   w = '{OP_Q_CMP,    C_MATCH,       S_Q_HIT,   S_Q_PROBE};
      S_Q_NEXT:  w = '{OP_Q_NEXT,   C_TRUE,        S_Q_BIN,   S_Q_BIN};
      S_Q_HIT:   w = '{OP_Q_HIT,    C_OUT_FREE,    S_IDLE,    S_Q_HIT};
      S_Q_MISS:  w = '{OP_Q_MISS,   C_OUT_FREE,    S_IDLE,    S_Q_MISS};
      default:   w = '{OP_IDLE,     C_TRUE,        S_IDLE,    S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bin_set_routing_lookup.sv =====
// Bin-set routing lookup. Load writes one table word per transfer; build walks the
// length words, records each bin's start and then the end entry. Query reads each bin's
// bounds and binary-searches it through the one table read port; with no hit it falls back.
// One item in flight; the input stalls while the microprogram runs.
// Synchronous active-low reset clears the step counter, config and output valid;
// table and bin index contents are undefined until loaded and built.
`default_nettype none

`include "bin_set_routing_lookup_defines.svh"

module bin_set_routing_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_BINS    = 64,
  parameter int unsigned LOOKAHEAD   = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [9:0]  in_addr,
  input  wire logic [9:0]  in_word,
  input  wire logic [7:0]  in_card,
  input  wire logic [6:0]  in_start_bin,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_dest_bin,
  output logic             out_matched,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [bsrl_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [10:0]                     cfg_wdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(MAX_BINS + 1);   // bin number / count
  localparam int unsigned CW = ((NW > 7) ? NW : 7) + 1; // current bin, may run past n
  localparam int unsigned LW = $clog2(LOOKAHEAD + 1);

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [6:0]  num_inter_bins_r;
  logic [10:0] table_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inter_bins_r <= '0;
      table_size_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bsrl_pkg::REG_NUM_INTER_BINS: num_inter_bins_r <= cfg_wdata[6:0];
        bsrl_pkg::REG_TABLE_SIZE:     table_size_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // bin count, clamped to what the index can hold
  logic [NW-1:0] bin_cnt;
  assign bin_cnt = (32'(num_inter_bins_r) > MAX_BINS) ? NW'(MAX_BINS)
                                                     : NW'(num_inter_bins_r);

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  bsrl_pkg::status_t stat;
  bsrl_pkg::ctrl_t   ctrl;

  bsrl_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  logic in_fire;
  assign in_stall = (ctrl.step != bsrl_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // ---------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------
  logic [10:0]   off_r;     // running bin offset during build
  logic [NW-1:0] bin_i_r;   // bin being indexed
  logic [NW-1:0] n_r;       // bin count latched at dispatch
  logic [7:0]    card_r;
  logic [CW-1:0] cur_r;     // bin under search
  logic [LW-1:0] look_r;    // bins checked so far
  logic [10:0]   lo_r;
  logic [10:0]   hi_r;
  logic [10:0]   mid_r;
  logic          out_valid_r;
  logic [1:0]    out_dest_r;
  logic          out_matched_r;

  // ---------------------------------------------------------------
  // set table: one write port (load), one registered read port
  // ---------------------------------------------------------------
  logic [9:0]    tbl_mem [TABLE_DEPTH];
  logic [9:0]    tbl_q_r;
  logic          tbl_oor_r;   // read address past depth reads as zero
  logic [10:0]   tbl_raddr;
  logic          tbl_we;
  logic [9:0]    tbl_val;
  logic [10:0]   mid_nxt;

  assign mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
  assign tbl_raddr = (ctrl.op == bsrl_pkg::OP_Q_PROBE) ? mid_nxt : off_r;
  assign tbl_we    = in_fire && (in_mode == bsrl_pkg::MODE_LOAD)
                     && (32'(in_addr) < TABLE_DEPTH);
  assign tbl_val   = tbl_oor_r ? '0 : tbl_q_r;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[AW'(32'(in_addr))] <= in_word;
    end
    tbl_q_r   <= tbl_mem[AW'(32'(tbl_raddr))];
    tbl_oor_r <= (32'(tbl_raddr) >= TABLE_DEPTH);
  end

  // ---------------------------------------------------------------
  // bin start index: written during build, read during query
  // ---------------------------------------------------------------
  logic [10:0]   bs_mem [MAX_BINS + 1];
  logic [10:0]   bs_q_r;
  logic          bs_we;
  logic [NW-1:0] bs_widx;
  logic [10:0]   bs_wdata;
  logic [NW-1:0] bs_ridx;

  assign bs_we    = (ctrl.op == bsrl_pkg::OP_B_INDEX) || (ctrl.op == bsrl_pkg::OP_B_END);
  assign bs_widx  = (ctrl.op == bsrl_pkg::OP_B_END) ? n_r : bin_i_r;
  assign bs_wdata = (ctrl.op == bsrl_pkg::OP_B_END) ? table_size_r : off_r;
  // upper bound of the bin is the next bin's start
  assign bs_ridx  = (ctrl.op == bsrl_pkg::OP_Q_RD_HI) ? NW'(cur_r + CW'(1)) : NW'(cur_r);

  always_ff @(posedge clk) begin
    if (bs_we) begin
      bs_mem[bs_widx] <= bs_wdata;
    end
    bs_q_r <= bs_mem[bs_ridx];
  end

  // ---------------------------------------------------------------
  // status to the sequencer
  // ---------------------------------------------------------------
  logic        out_free;
  logic        out_load;
  logic [11:0] off_sum;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = out_free &&
                    ((ctrl.op == bsrl_pkg::OP_Q_HIT) || (ctrl.op == bsrl_pkg::OP_Q_MISS));
  // saturating advance past length word and its cards
  assign off_sum  = 12'(off_r) + 12'(tbl_val) + 12'd1;

  always_comb begin
    stat.in_fire     = in_fire;
    stat.mode        = in_mode;
    stat.bin_done    = (bin_i_r >= n_r);
    stat.scan_done   = (look_r == LW'(LOOKAHEAD)) || (cur_r >= CW'(n_r));
    stat.range_empty = !((12'(lo_r) + 12'd1) < 12'(hi_r));
    stat.match       = (tbl_val == 10'(card_r));
    stat.out_free    = out_free;
  end

  // ---------------------------------------------------------------
  // datapath, one action per control word
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (ctrl.op)
      bsrl_pkg::OP_IDLE: begin
        if (in_fire) begin
          n_r     <= bin_cnt;
          off_r   <= 11'(bsrl_pkg::HEADER_WORDS);
          bin_i_r <= '0;
          card_r  <= in_card;
          cur_r   <= CW'(in_start_bin);
          look_r  <= '0;
        end
      end
      bsrl_pkg::OP_B_ADV: begin
        off_r   <= (off_sum > 12'(bsrl_pkg::OFFSET_MAX)) ? bsrl_pkg::OFFSET_MAX
                                                         : off_sum[10:0];
        bin_i_r <= bin_i_r + NW'(1);
      end
      bsrl_pkg::OP_Q_RD_HI:  lo_r <= bs_q_r;
      bsrl_pkg::OP_Q_SET_HI: hi_r <= bs_q_r;
      bsrl_pkg::OP_Q_PROBE:  mid_r <= mid_nxt;
      bsrl_pkg::OP_Q_CMP: begin
        if (tbl_val > 10'(card_r)) begin
          hi_r <= mid_r;
        end else if (tbl_val < 10'(card_r)) begin
          lo_r <= mid_r;
        end
      end
      bsrl_pkg::OP_Q_NEXT: begin
        cur_r  <= cur_r + CW'(1);
        look_r <= look_r + LW'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------
  // output register; a finished query waits here until taken
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (ctrl.op == bsrl_pkg::OP_Q_HIT) begin
        out_dest_r    <= 2'(cur_r);
        out_matched_r <= 1'b1;
      end else begin
        out_dest_r    <= 2'(n_r);
        out_matched_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dest_bin = out_dest_r;
  assign out_matched  = out_matched_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  `BSRL_ASSERT_IMP(a_no_overrun, out_load, !out_valid_r || !out_stall, "result overwritten")
  `BSRL_ASSERT_IMP(a_probe_inside, ctrl.step == bsrl_pkg::S_Q_CMP, (lo_r < mid_r) && (mid_r < hi_r), "probe outside range")
  `BSRL_ASSERT_IMP(a_scan_bound, ctrl.step == bsrl_pkg::S_Q_LO, (look_r < LW'(LOOKAHEAD)) && (cur_r < CW'(n_r)), "bin scan past bound")
  `BSRL_ASSERT_NXT(a_query_starts, in_fire && (in_mode == bsrl_pkg::MODE_QUERY), ctrl.step == bsrl_pkg::S_Q_BIN, "query did not start")

endmodule

`default_nettype wire

// ===== hw/rtl/bsrl_seq.sv =====
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
// Depends on bsrl_pkg.
`default_nettype none

module bsrl_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bsrl_pkg::status_t stat,
  output bsrl_pkg::ctrl_t        ctrl
);

  bsrl_pkg::step_t  pc_r;
  bsrl_pkg::step_t  pc_nxt;
  bsrl_pkg::uword_t uw;
  logic             taken;

  assign uw = bsrl_pkg::ucode(pc_r);

  // next step
  always_comb begin
    taken  = 1'b1;
    pc_nxt = uw.tgt_t;
    case (uw.cond)
      bsrl_pkg::C_TRUE:        taken = 1'b1;
      bsrl_pkg::C_BIN_DONE:    taken = stat.bin_done;
      bsrl_pkg::C_SCAN_DONE:   taken = stat.scan_done;
      bsrl_pkg::C_RANGE_EMPTY: taken = stat.range_empty;
      bsrl_pkg::C_MATCH:       taken = stat.match;
      bsrl_pkg::C_OUT_FREE:    taken = stat.out_free;
      default:                 taken = 1'b0;
    endcase
    if (uw.cond == bsrl_pkg::C_DISPATCH) begin
      pc_nxt = bsrl_pkg::S_IDLE;
      if (stat.in_fire) begin
        case (stat.mode)
          bsrl_pkg::MODE_BUILD: pc_nxt = bsrl_pkg::S_B_LOOP;
          bsrl_pkg::MODE_QUERY: pc_nxt = bsrl_pkg::S_Q_BIN;
          default:              pc_nxt = bsrl_pkg::S_IDLE;
        endcase
      end
    end else if (!taken) begin
      pc_nxt = uw.tgt_f;
    end
  end

  // control outputs
  always_comb begin
    ctrl.step = pc_r;
    ctrl.op   = uw.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bsrl_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for bin_set_routing_lookup: table loads, index builds and
// route queries, predicted by a shadow of the table and bin index kept in this module.
// Depends on bsrl_pkg (mode codes, register indexes) and the RTL top level.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 1024;     // table words
  localparam int BINS_MAX    = 64;       // bin count clamp
  localparam int AHEAD       = 5;        // bins checked per query
  localparam int FIRST_BIN   = 3;        // words 0..2 are header
  localparam int OFF_SAT     = 2047;     // build offset saturates here
  localparam int SETTLE      = 200;      // room for a build of 64 bins to finish
  localparam int HOLD_CYCLES = 300;      // long receiver hold-off
  localparam int ITEM_GOAL   = 1870;     // directed rows plus ~1850 random
  localparam int CALM_AT     = 1650;     // no idling on either side past this

  typedef struct packed {
    logic [1:0] dest;
    logic       matched;
  } route_t;

  typedef enum int {
    PH_WELL,       // well-formed table, exact bounds, mostly hitting queries
    PH_WIDE,       // 64 tiny bins
    PH_OVER_BINS,  // bin count register above the clamp
    PH_EMPTY,      // no bins, zero table size
    PH_OVERFLOW,   // starts run past the table and saturate
    PH_NOISE       // random registers against a random table
  } phase_t;

  typedef struct packed {
    bsrl_pkg::mode_t mode;
    logic [9:0]      addr;
    logic [9:0]      word;
    logic [7:0]      card;
    logic [6:0]      start;
    logic            typed;   // expected route written in the row
    route_t          res;
  } dir_row_t;

  // Two bins: bin 0 at word 3 holds {10, 20, 30}, bin 1 at word 7 holds {5, 255}.
  // Registers: two bins, table size 10. Misses fall back to bin count 2.
  localparam dir_row_t DIR_ROWS [20] = '{
    '{bsrl_pkg::MODE_LOAD,  10'd0,    10'd0,    8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd3,    10'd3,    8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd4,    10'd10,   8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd5,    10'd20,   8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd6,    10'd30,   8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd7,    10'd2,    8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd8,    10'd5,    8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd9,    10'd255,  8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_LOAD,  10'd1023, 10'd1023, 8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_NOP,   10'd1023, 10'd1023, 8'd255, 7'd127, 1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_BUILD, 10'd0,    10'd0,    8'd0,   7'd0,   1'b0, '{2'd0, 1'b0}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd20,  7'd0,   1'b1, '{2'd0, 1'b1}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd10,  7'd0,   1'b1, '{2'd0, 1'b1}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd30,  7'd0,   1'b1, '{2'd0, 1'b1}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd255, 7'd0,   1'b1, '{2'd1, 1'b1}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd5,   7'd1,   1'b1, '{2'd1, 1'b1}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd0,   7'd0,   1'b1, '{2'd2, 1'b0}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd255, 7'd2,   1'b1, '{2'd2, 1'b0}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd255, 7'd127, 1'b1, '{2'd2, 1'b0}},
    '{bsrl_pkg::MODE_QUERY, 10'd0,    10'd0,    8'd11,  7'd0,   1'b1, '{2'd2, 1'b0}}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [1:0]                     in_mode;
  logic [9:0]                     in_addr;
  logic [9:0]                     in_word;
  logic [7:0]                     in_card;
  logic [6:0]                     in_start_bin;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_dest_bin;
  logic                           out_matched;
  logic                           cfg_we;
  logic [bsrl_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [10:0]                    cfg_wdata;

  // Shadow of the block: table words, which words were ever loaded, bin index, registers
  bit [9:0]   tbl [DEPTH];
  bit         tbl_written [DEPTH];
  int         bin_base [BINS_MAX+1];
  logic [6:0] cfg_bins;
  logic [10:0] cfg_size;

  route_t route_q [$];   // routes owed by the block, oldest first
  int     stim_cnt;      // load/build/query transfers driven
  int     results_seen;
  int     fail_cnt;
  bit     calm;          // final stretch, nobody idles
  bit     gaps_on;       // sender gaps enabled for the current phase

  bin_set_routing_lookup u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_addr     (in_addr),
    .in_word     (in_word),
    .in_card     (in_card),
    .in_start_bin(in_start_bin),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_dest_bin(out_dest_bin),
    .out_matched (out_matched),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Words past the table read as zero.
  function automatic int tbl_rd(int a);
    return (a < DEPTH) ? int'(tbl[a]) : 0;
  endfunction

  function automatic int eff_bins();
    return (cfg_bins > BINS_MAX) ? BINS_MAX : int'(cfg_bins);
  endfunction

  // Walks the length words from the first bin. With commit set it records the
  // bin starts; either way it returns the first never-loaded word it would read.
  function automatic int index_walk(bit commit);
    int n, off, i, hole;
    n    = eff_bins();
    off  = FIRST_BIN;
    hole = -1;
    for (i = 0; i < n; i++) begin
      if (commit) bin_base[i] = off;
      if (hole < 0 && off < DEPTH && !tbl_written[off]) hole = off;
      off = off + tbl_rd(off) + 1;
      if (off > OFF_SAT) off = OFF_SAT;
    end
    if (commit) bin_base[n] = int'(cfg_size);
    return hole;
  endfunction

  // Binary search of up to AHEAD bins from start; the end of the last bin is
  // table_size. Also reports the first never-loaded word the search would probe.
  function automatic route_t route_walk(int card, int start, output int hole);
    int     n, i, lo, hi, mid, v, hit_bin;
    bit     found;
    route_t r;
    n       = eff_bins();
    hole    = -1;
    found   = 1'b0;
    hit_bin = 0;
    for (i = 0; i < AHEAD && start + i < n && !found; i++) begin
      lo = bin_base[start+i];
      hi = bin_base[start+i+1];
      // a bin whose start is not below its end minus one holds nothing
      while (lo + 1 < hi && !found) begin
        mid = (hi - lo) / 2 + lo;
        if (hole < 0 && mid < DEPTH && !tbl_written[mid]) hole = mid;
        v = tbl_rd(mid);
        if (v > card) hi = mid;
        else if (v < card) lo = mid;
        else begin
          found   = 1'b1;
          hit_bin = start + i;
        end
      end
    end
    r.dest    = found ? hit_bin[1:0] : n[1:0];
    r.matched = found;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Inputs change on the falling edge. The item is predicted when offered (it
  // is certain to go in before the next one), and the task returns at the
  // rising edge that takes the transfer; valid stays up until the next falling
  // edge, where the caller either offers more or drops it.
  task automatic send_item(bsrl_pkg::mode_t m, int addr, int word, int card, int start,
                           bit typed = 1'b0, route_t typed_res = '0);
    int     gap, hole;
    route_t r;
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_mode      = m;
    in_addr      = addr[9:0];
    in_word      = word[9:0];
    in_card      = card[7:0];
    in_start_bin = start[6:0];
    case (m)
      bsrl_pkg::MODE_LOAD: begin
        tbl[addr]         = word[9:0];
        tbl_written[addr] = 1'b1;
      end
      bsrl_pkg::MODE_BUILD: void'(index_walk(1'b1));
      bsrl_pkg::MODE_QUERY: begin
        r = route_walk(card, start, hole);
        route_q.push_back(typed ? typed_res : r);
      end
      default: ;
    endcase
    if (m != bsrl_pkg::MODE_NOP) stim_cnt++;
    calm = (stim_cnt >= CALM_AT);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(int a, int w);
    send_item(bsrl_pkg::MODE_LOAD, a, w, $urandom_range(0, 255), $urandom_range(0, 127));
  endtask

  task automatic send_nop();
    send_item(bsrl_pkg::MODE_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 255), $urandom_range(0, 127));
  endtask

  // Table contents are undefined until loaded, so any word a build would read
  // and nobody loaded gets a random load first.
  task automatic send_build();
    int hole;
    hole = index_walk(1'b0);
    while (hole >= 0) begin
      send_load(hole, $urandom_range(0, 1023));
      hole = index_walk(1'b0);
    end
    send_item(bsrl_pkg::MODE_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 255), $urandom_range(0, 127));
  endtask

  // Same for the words a query's searches would probe.
  task automatic send_query(int card, int start);
    int     hole;
    route_t r;
    r = route_walk(card, start, hole);
    while (hole >= 0) begin
      send_load(hole, $urandom_range(0, 1023));
      r = route_walk(card, start, hole);
    end
    send_item(bsrl_pkg::MODE_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023),
              card, start);
  endtask

  // Register writes go in only while the block is idle.
  task automatic write_reg(logic [bsrl_pkg::CFG_IDX_W-1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    if (idx == bsrl_pkg::REG_NUM_INTER_BINS) cfg_bins = val[6:0];
    else cfg_size = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Every owed route delivered, then room for a trailing build to finish.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One phase: registers, table image, build, then a run of queries with some
  // stray loads, rebuilds and no-ops mixed in.
  task automatic run_phase(phase_t kind, bit full_size);
    int          nb, b, k, a, q, nq, lo, hi, card, start_b, end_addr, pick;
    int          lens [BINS_MAX];
    bit          swap;
    logic [6:0]  bins_reg;
    logic [10:0] size_reg;
    wait_idle();
    gaps_on = ($urandom_range(0, 3) != 0);
    case (kind)
      PH_WIDE, PH_OVER_BINS, PH_OVERFLOW: nb = BINS_MAX;
      PH_EMPTY: nb = 0;
      default: nb = $urandom_range(1, 8);
    endcase
    end_addr = FIRST_BIN;
    for (b = 0; b < nb; b++) begin
      lens[b] = (nb > 8) ? $urandom_range(0, 2) : $urandom_range(0, 9);
      end_addr += lens[b] + 1;
    end
    bins_reg = nb[6:0];
    size_reg = end_addr[10:0];
    pick     = $urandom_range(0, 9);
    case (kind)
      PH_OVER_BINS: bins_reg = 7'd127;
      PH_EMPTY:     size_reg = 11'd0;
      PH_OVERFLOW:  size_reg = 11'd2047;
      PH_NOISE: begin
        bins_reg = 7'($urandom_range(0, 127));
        size_reg = 11'($urandom_range(0, 2047));
      end
      PH_WELL: begin
        if (full_size || pick == 0) size_reg = 11'd1024;
        else if (pick == 1) begin
          // last bin ends short of its cards
          k        = $urandom_range(1, 3);
          size_reg = 11'(end_addr - k);
        end else if (pick == 2) bins_reg = 7'(nb + $urandom_range(1, 3));
      end
      default: ;
    endcase
    // upper data bits are don't-care for the bin count register
    swap = 1'($urandom_range(0, 1));
    for (k = 0; k < 2; k++) begin
      if ((k == 0) ^ swap) write_reg(bsrl_pkg::REG_TABLE_SIZE, size_reg);
      else write_reg(bsrl_pkg::REG_NUM_INTER_BINS, {4'($urandom_range(0, 15)), bins_reg});
    end

    if (kind == PH_OVERFLOW) begin
      // bin 0 runs to word 1020, where bin 1's length throws bin 2 to 2044; later bins
      // sit past the table (reads as zero) and the running offset saturates
      send_load(FIRST_BIN, 1016);
      send_load(1020, 1023);
    end else begin
      a = FIRST_BIN;
      for (b = 0; b < nb; b++) begin
        send_load(a, lens[b]);
        card = $urandom_range(0, 200);
        for (k = 0; k < lens[b]; k++) begin
          if ($urandom_range(0, 19) == 0) send_nop();
          send_load(a + 1 + k, card);
          card += $urandom_range(1, 60);
        end
        a += lens[b] + 1;
      end
    end
    send_build();

    nq = $urandom_range(15, 50);
    for (q = 0; q < nq; q++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) send_load($urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (pick < 5) send_build();
      else if (pick < 7) send_nop();
      else begin
        nb      = eff_bins();
        card    = $urandom_range(0, 255);
        start_b = $urandom_range(0, 127);
        if (nb > 0 && pick < 80) begin
          // take a card that sits in some bin, start up to five bins before it so
          // that it is sometimes past the lookahead window
          b  = $urandom_range(0, nb - 1);
          lo = bin_base[b];
          hi = bin_base[b+1];
          if (hi > lo + 1) begin
            a = $urandom_range(lo + 1, hi - 1);
            if (a < DEPTH && tbl_written[a] && tbl[a] < 256) card = tbl[a];
          end
          k       = $urandom_range(0, 5);
          start_b = (b > k) ? b - k : 0;
        end
        send_query(card, start_b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int     ph;
    phase_t kind;
    int     pick;
    in_valid     = 1'b0;
    in_mode      = bsrl_pkg::MODE_LOAD;
    in_addr      = '0;
    in_word      = '0;
    in_card      = '0;
    in_start_bin = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    cfg_bins     = '0;
    cfg_size     = '0;
    stim_cnt     = 0;
    fail_cnt     = 0;
    calm         = 1'b0;
    gaps_on      = 1'b1;
    rst_n        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: small two-bin table, every mode, field extremes, misses and
    // a start bin at and far beyond the bin count
    write_reg(bsrl_pkg::REG_NUM_INTER_BINS, 11'd2);
    write_reg(bsrl_pkg::REG_TABLE_SIZE, 11'd10);
    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].mode, DIR_ROWS[i].addr, DIR_ROWS[i].word, DIR_ROWS[i].card,
                DIR_ROWS[i].start, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // random: the corner phases first, then mostly well-formed tables
    ph = 0;
    while (stim_cnt < ITEM_GOAL) begin
      if (ph < 4) kind = phase_t'(ph + 1);
      else begin
        pick = $urandom_range(0, 19);
        if (pick < 14) kind = PH_WELL;
        else if (pick < 17) kind = PH_NOISE;
        else kind = phase_t'($urandom_range(1, 4));
      end
      run_phase(kind, ph == 4);
      ph++;
    end

    wait_idle();
    if (fail_cnt == 0 && route_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts in on/off stretches, plus one long hold-off
  // once queries are flowing so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left, stretch;
    bit stall_on, held;
    out_stall  = 1'b0;
    stall_left = 0;
    stretch    = 0;
    stall_on   = 1'b1;
    held       = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        stretch  = 256;
        stall_on = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      if (stall_left > 0) stall_left--;
      else if (!held && results_seen >= 40) begin
        stall_left = HOLD_CYCLES;
        held       = 1'b1;
      end else if (stall_on && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      out_stall = (stall_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each transfer against the oldest owed route, field by field
  // ---------------------------------------------------------------------------
  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    route_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (route_q.size() == 0) begin
        note_fail($sformatf("route with none owed: dest_bin %0d matched %0d",
                            out_dest_bin, out_matched));
      end else begin
        want = route_q.pop_front();
        if (out_dest_bin !== want.dest)
          note_fail($sformatf("dest_bin expected %0d got %0d", want.dest, out_dest_bin));
        if (out_matched !== want.matched)
          note_fail($sformatf("matched expected %0d got %0d", want.matched, out_matched));
      end
    end
  end

  initial begin
    results_seen = 0;
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bsrl_pkg.sv
hw/rtl/bsrl_seq.sv
hw/rtl/bin_set_routing_lookup.sv
tb/tb.sv
